// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by matrix_chain_min_cost_core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising edge of clk while rst is low.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition must never be true at a rising edge of clk while rst is low.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   `ASSERT_CLK(lbl, clk, rst, !(cond), msg)
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// ===== hdl/mcmc_pkg.sv =====
// ----------------------------------------------------------------------------
// mcmc_pkg
// Shared types and constants of the matrix chain minimum cost core.
// ----------------------------------------------------------------------------
`default_nettype none

package mcmc_pkg;

   localparam int DIM_FIELD_W  = 10;
   localparam int COST_FIELD_W = 35;
   localparam int MAX_DIMS_DEF = 32;
   localparam int DIM_BITS_DEF = 10;

   typedef struct packed {
      logic [DIM_FIELD_W-1:0] dim_value;
      logic                   last;
   } req_type;

   typedef struct packed {
      logic [COST_FIELD_W-1:0] min_cost;
      logic                    error;
   } rsp_type;

   // Control from the sequencer to the split datapath.
   typedef struct packed {
      logic load_dims;   // latch the outer product of the cell's end dimensions
      logic data_valid;  // memory read data of one split point is present
      logic data_first;  // that split point is the first of its cell
   } split_ctrl_type;

endpackage

`default_nettype wire

// ===== hdl/mcmc_ram.sv =====
// ----------------------------------------------------------------------------
// mcmc_ram
// Generic synchronous RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module mcmc_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr_a,
   output logic      [WIDTH-1:0]  rd_data_a,
   input  wire logic [ADDR_W-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

`default_nettype wire

// ===== hdl/mcmc_split_unit.sv =====
// ----------------------------------------------------------------------------
// mcmc_split_unit
// Evaluates one split point per cycle and keeps the running minimum of a cell.
// ----------------------------------------------------------------------------
`default_nettype none

module mcmc_split_unit #(
   parameter int DIM_BITS = mcmc_pkg::DIM_BITS_DEF,
   parameter int COST_W   = 3 * DIM_BITS + 5
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire mcmc_pkg::split_ctrl_type ctrl,
   input  wire logic [DIM_BITS-1:0]    dim_a,
   input  wire logic [DIM_BITS-1:0]    dim_b,
   input  wire logic [COST_W-1:0]      cost_left,
   input  wire logic [COST_W-1:0]      cost_right,
   output logic                        busy,
   output logic [COST_W-1:0]           best
);

   logic [2*DIM_BITS-1:0] dij_ff;
   logic [3*DIM_BITS-1:0] prod;
   logic [COST_W-1:0]     prod_ff;
   logic [COST_W-1:0]     sum_ff;
   logic                  valid_ff;
   logic                  first_ff;
   logic [COST_W-1:0]     cand;
   logic [COST_W-1:0]     best_ff;

   // When loading, dim_a/dim_b are the cell's end dimensions; later dim_a is d[k].
   assign prod = {{DIM_BITS{1'b0}}, dij_ff} * {{(2*DIM_BITS){1'b0}}, dim_a};
   assign cand = prod_ff + sum_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load_dims) begin
         dij_ff <= {{DIM_BITS{1'b0}}, dim_a} * {{DIM_BITS{1'b0}}, dim_b};
      end
      prod_ff  <= COST_W'(prod);
      sum_ff   <= cost_left + cost_right;
      first_ff <= ctrl.data_first;
      if (valid_ff && (first_ff || cand < best_ff)) begin
         best_ff <= cand;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctrl.data_valid;
      end
   end

   assign busy = valid_ff;
   assign best = best_ff;

endmodule

`default_nettype wire

// ===== hdl/matrix_chain_min_cost_core.sv =====
// ----------------------------------------------------------------------------
// matrix_chain_min_cost_core
// Least scalar multiplication count of a matrix chain by interval dynamic
// programming over a cost table held in a synchronous RAM.
// ----------------------------------------------------------------------------
// Usage: the dimension list of a chain arrives on the req channel, one value
// per transfer, with last set on the final value. n dimensions describe n-1
// matrices. Non-final values are accepted back to back.
// After the final value the core fills the interval cost table row by row
// and returns one rsp transfer carrying min_cost and error.
// Fill: each row starts by zeroing its diagonal; each cell (i,j) reads its
// end dimensions, streams its j-i split points through the split unit,
// drains it and writes back the minimum; the end reads the corner. The split
// rate of one per cycle is set by the two read ports of the cost RAM.
// Fewer than two values, or more than MAX_DIMS, give min_cost 0 and error 1
// without a table fill.
// Reset (synchronous, active high) empties the list and drops any pending
// result; the RAMs are not cleared, since every entry read is written first.
// A stalled rsp holds its payload; the next list may be loaded meanwhile, and
// its result waits until the previous one has been taken, with req not ready.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_chain_min_cost_core #(
   parameter int MAX_DIMS = mcmc_pkg::MAX_DIMS_DEF,
   parameter int DIM_BITS = mcmc_pkg::DIM_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire mcmc_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output mcmc_pkg::rsp_type      rsp_payload
);

   localparam int IW     = $clog2(MAX_DIMS);
   localparam int CNT_W  = $clog2(MAX_DIMS + 1);
   // Bound of any candidate cost: (MAX_DIMS-1) products of three dimensions.
   localparam int COST_W = 3 * DIM_BITS + $clog2(MAX_DIMS);
   localparam int TAB_AW = 2 * IW;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ROW,
      S_CELL,
      S_CELL_W,
      S_SPLIT,
      S_DRAIN,
      S_FINAL_RD,
      S_FINAL_W,
      S_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  ovf_ff, ovf_in;
   logic [IW-1:0]         last_ff, last_in;
   logic [IW-1:0]         i_ff, i_in;
   logic [IW-1:0]         j_ff, j_in;
   logic [IW-1:0]         k_ff, k_in;
   logic                  v1_ff, v1_in;
   logic                  first1_ff, first1_in;
   logic [COST_W-1:0]     result_ff, result_in;
   logic                  err_ff, err_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   mcmc_pkg::rsp_type     rsp_payload_ff, rsp_payload_in;

   logic                  req_fire;
   logic                  has_room;
   logic [CNT_W-1:0]      n_new;
   logic                  ovf_new;

   logic                  dim_we;
   logic [IW-1:0]         dim_addr_a, dim_addr_b;
   logic [DIM_BITS-1:0]   dim_rd_a, dim_rd_b;

   logic                  tab_we;
   logic [TAB_AW-1:0]     tab_wr_addr, tab_addr_a, tab_addr_b;
   logic [COST_W-1:0]     tab_wr_data, tab_rd_a, tab_rd_b;

   mcmc_pkg::split_ctrl_type split_ctrl;
   logic                  split_busy;
   logic [COST_W-1:0]     split_best;
   logic                  drained;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign has_room  = (cnt_ff < CNT_W'(MAX_DIMS));
   assign n_new     = has_room ? cnt_ff + CNT_W'(1) : cnt_ff;
   assign ovf_new   = ovf_ff || !has_room;
   assign drained   = !v1_ff && !split_busy;

   // Values beyond the store are dropped; the list is flagged instead.
   assign dim_we = req_fire && has_room;

   mcmc_ram #(
      .WIDTH (DIM_BITS),
      .DEPTH (MAX_DIMS),
      .ADDR_W(IW)
   ) u_dim_ram (
      .clock    (clock),
      .wr_en    (dim_we),
      .wr_addr  (cnt_ff[IW-1:0]),
      .wr_data  (DIM_BITS'(req_payload.dim_value)),
      .rd_addr_a(dim_addr_a),
      .rd_data_a(dim_rd_a),
      .rd_addr_b(dim_addr_b),
      .rd_data_b(dim_rd_b)
   );

   // The cost table is addressed by the concatenated interval ends {i, j}.
   mcmc_ram #(
      .WIDTH (COST_W),
      .DEPTH (2 ** TAB_AW),
      .ADDR_W(TAB_AW)
   ) u_cost_ram (
      .clock    (clock),
      .wr_en    (tab_we),
      .wr_addr  (tab_wr_addr),
      .wr_data  (tab_wr_data),
      .rd_addr_a(tab_addr_a),
      .rd_data_a(tab_rd_a),
      .rd_addr_b(tab_addr_b),
      .rd_data_b(tab_rd_b)
   );

   mcmc_split_unit #(
      .DIM_BITS(DIM_BITS),
      .COST_W  (COST_W)
   ) u_split (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (split_ctrl),
      .dim_a     (dim_rd_a),
      .dim_b     (dim_rd_b),
      .cost_left (tab_rd_a),
      .cost_right(tab_rd_b),
      .busy      (split_busy),
      .best      (split_best)
   );

   // Memory addressing. Reads issued in one cycle return in the next.
   always_comb begin
      dim_addr_a = (state_ff == S_CELL) ? i_ff - IW'(1) : k_ff;
      dim_addr_b = j_ff;
      tab_addr_a = (state_ff == S_FINAL_RD) ? {IW'(1), last_ff} : {i_ff, k_ff};
      tab_addr_b = {k_ff + IW'(1), j_ff};
      // A row starts by zeroing its diagonal; a cell ends by storing its minimum.
      tab_we      = (state_ff == S_ROW) || (state_ff == S_DRAIN && drained);
      tab_wr_addr = (state_ff == S_ROW) ? {i_ff, i_ff} : {i_ff, j_ff};
      tab_wr_data = (state_ff == S_ROW) ? '0 : split_best;
      split_ctrl.load_dims  = (state_ff == S_CELL_W);
      split_ctrl.data_valid = v1_ff;
      split_ctrl.data_first = first1_ff;
   end

   // Sequencer: load, fill rows from the bottom, read the corner, respond; a bad list goes straight to the response.
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      ovf_in         = ovf_ff;
      last_in        = last_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      k_in           = k_ff;
      v1_in          = 1'b0;
      first1_in      = 1'b0;
      result_in      = result_ff;
      err_in         = err_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cnt_in = n_new;
               ovf_in = ovf_new;
               if (req_payload.last) begin
                  cnt_in  = '0;
                  ovf_in  = 1'b0;
                  last_in = IW'(n_new - CNT_W'(1));
                  i_in    = IW'(n_new - CNT_W'(1));
                  if (ovf_new || n_new < CNT_W'(2)) begin
                     result_in = '0;
                     err_in    = 1'b1;
                     state_in  = S_DONE;
                  end else begin
                     err_in   = 1'b0;
                     state_in = S_ROW;
                  end
               end
            end
         end
         S_ROW: begin
            if (i_ff == last_ff) begin
               if (i_ff == IW'(1)) begin
                  state_in = S_FINAL_RD;
               end else begin
                  i_in = i_ff - IW'(1);
               end
            end else begin
               j_in     = i_ff + IW'(1);
               state_in = S_CELL;
            end
         end
         S_CELL: begin
            state_in = S_CELL_W;
         end
         S_CELL_W: begin
            k_in     = i_ff;
            state_in = S_SPLIT;
         end
         S_SPLIT: begin
            v1_in     = 1'b1;
            first1_in = (k_ff == i_ff);
            if (k_ff == j_ff - IW'(1)) begin
               state_in = S_DRAIN;
            end else begin
               k_in = k_ff + IW'(1);
            end
         end
         S_DRAIN: begin
            if (drained) begin
               if (j_ff == last_ff) begin
                  if (i_ff == IW'(1)) begin
                     state_in = S_FINAL_RD;
                  end else begin
                     i_in     = i_ff - IW'(1);
                     state_in = S_ROW;
                  end
               end else begin
                  j_in     = j_ff + IW'(1);
                  state_in = S_CELL;
               end
            end
         end
         S_FINAL_RD: begin
            state_in = S_FINAL_W;
         end
         S_FINAL_W: begin
            result_in = tab_rd_a;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_payload_in.min_cost = mcmc_pkg::COST_FIELD_W'(result_ff);
               rsp_payload_in.error    = err_ff;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      last_ff        <= last_in;
      i_ff           <= i_in;
      j_ff           <= j_in;
      k_ff           <= k_in;
      first1_ff      <= first1_in;
      result_ff      <= result_in;
      err_ff         <= err_in;
      rsp_payload_ff <= rsp_payload_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         v1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         v1_ff        <= v1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`include "assert_macros.svh"

   // A split point always lies strictly inside its interval.
   `ASSERT_NEVER(a_split_in_range, clock, reset, state_ff == S_SPLIT && k_ff >= j_ff, "split point outside interval")
   // No table write while split data of the current cell is still in flight.
   `ASSERT_NEVER(a_write_after_drain, clock, reset, tab_we && (v1_ff || split_busy), "cost write before drain")
   // An error result never carries a cost.
   `ASSERT_CLK(a_error_zero_cost, clock, reset, rsp_valid_ff && rsp_payload_ff.error |-> rsp_payload_ff.min_cost == '0, "error result with nonzero cost")
   // The stored count never passes the capacity of the dimension store.
   `ASSERT_CLK(a_count_bound, clock, reset, cnt_ff <= CNT_W'(MAX_DIMS), "dimension count past capacity")

endmodule

`default_nettype wire

// ===== tb/sv/matrix_chain_cost_checker.sv =====
// ----------------------------------------------------------------------------
// matrix_chain_cost_checker
// Watches both channels of the matrix chain core, predicts the minimum cost
// of each closed dimension list and compares every rsp transfer against it.
// ----------------------------------------------------------------------------
module matrix_chain_cost_checker #(
   parameter int MAX_DIMS = mcmc_pkg::MAX_DIMS_DEF,
   parameter int DIM_BITS = mcmc_pkg::DIM_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  mcmc_pkg::req_type req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  mcmc_pkg::rsp_type rsp_payload,
   output int                mismatch_count,
   output int                costs_outstanding
);

   logic [DIM_BITS-1:0] chain_dims [MAX_DIMS];
   int unsigned         chain_len;
   bit                  chain_overflow;
   mcmc_pkg::rsp_type   expected_costs [$];

   initial begin
      mismatch_count    = 0;
      costs_outstanding = 0;
      chain_len         = 0;
      chain_overflow    = 1'b0;
   end

   // Interval DP over the stored chain: cell (i,j) is the cheapest split of
   // matrices i..j, with matrix i sized dims[i-1] x dims[i].
   function automatic logic [mcmc_pkg::COST_FIELD_W-1:0] chain_min_cost(int n);
      longint unsigned span_cost [MAX_DIMS][MAX_DIMS];
      longint unsigned best;
      longint unsigned trial;
      bit              have_best;
      for (int i = n - 1; i >= 1; i--) begin
         span_cost[i][i] = 0;
         for (int j = i + 1; j < n; j++) begin
            best      = 0;
            have_best = 1'b0;
            for (int k = i; k < j; k++) begin
               trial = longint'(chain_dims[i-1]) * chain_dims[k] * chain_dims[j]
                       + span_cost[i][k] + span_cost[k+1][j];
               if (!have_best || trial < best) begin
                  best      = trial;
                  have_best = 1'b1;
               end
            end
            span_cost[i][j] = best;
         end
      end
      return span_cost[1][n-1][mcmc_pkg::COST_FIELD_W-1:0];
   endfunction

   // Values beyond the store are dropped but poison the chain.
   task automatic absorb_dim(input mcmc_pkg::req_type item);
      mcmc_pkg::rsp_type closing;
      if (chain_len < MAX_DIMS) begin
         chain_dims[chain_len] = item.dim_value[DIM_BITS-1:0];
         chain_len++;
      end else begin
         chain_overflow = 1'b1;
      end
      if (item.last) begin
         closing.error    = chain_overflow || chain_len < 2;
         closing.min_cost = closing.error ? '0 : chain_min_cost(chain_len);
         expected_costs.push_back(closing);
         chain_len      = 0;
         chain_overflow = 1'b0;
      end
   endtask

   always @(posedge clock) begin : track
      mcmc_pkg::rsp_type want;
      if (reset) begin
         chain_len      = 0;
         chain_overflow = 1'b0;
         expected_costs.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_costs.size() == 0) begin
               $display("%0t: unexpected result: expected none, got min_cost %0d error %0b",
                        $time, rsp_payload.min_cost, rsp_payload.error);
               mismatch_count++;
            end else begin
               want = expected_costs.pop_front();
               if (rsp_payload.min_cost !== want.min_cost) begin
                  $display("%0t: min_cost mismatch: expected %0d, got %0d",
                           $time, want.min_cost, rsp_payload.min_cost);
                  mismatch_count++;
               end
               if (rsp_payload.error !== want.error) begin
                  $display("%0t: error flag mismatch: expected %0b, got %0b",
                           $time, want.error, rsp_payload.error);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready)
            absorb_dim(req_payload);
      end
      costs_outstanding <= expected_costs.size();
   end

endmodule

// ===== tb/sv/tb_matrix_chain_min_cost_core.sv =====
// ----------------------------------------------------------------------------
// tb_matrix_chain_min_cost_core
// Feeds dimension lists into the matrix chain core, directed corner chains
// first, then random chains under several idle and stall profiles and a long
// rsp hold-off, while a checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_matrix_chain_min_cost_core;

   localparam int     CLK_PERIOD      = 12;
   localparam longint TIMEOUT_CYCLES  = 2_000_000;
   localparam int     HOLD_CYCLES     = 4000;
   localparam int     ITEMS_PER_PHASE = 215;
   localparam int     SETTLE_CYCLES   = 50;
   localparam int     DIM_W           = mcmc_pkg::DIM_FIELD_W;
   localparam int     MAX_DIMS        = mcmc_pkg::MAX_DIMS_DEF;

   // Idle profile of each random phase, in percent of cycles.
   localparam int SEND_IDLE_PCT  [4] = '{0, 73, 0, 31};
   localparam int RECV_STALL_PCT [4] = '{0, 0, 73, 31};

   // How the values of one random chain are drawn.
   typedef enum int {
      DIMS_UNIFORM,
      DIMS_EXTREME,
      DIMS_TINY,
      DIMS_NEAR_MAX,
      DIMS_WITH_ZERO
   } dim_profile_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   mcmc_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   mcmc_pkg::rsp_type rsp_payload;

   int mismatch_count;
   int costs_outstanding;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   // The stimulus asks for a long rsp hold-off by bumping hold_requests; the
   // receiver process notices the change and counts the stretch down itself.
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   matrix_chain_min_cost_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   matrix_chain_cost_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_payload       (req_payload),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_payload       (rsp_payload),
      .mismatch_count    (mismatch_count),
      .costs_outstanding (costs_outstanding)
   );

   // Receiver: random stalls at the current rate, or a solid hold-off while a
   // requested stretch is running. The rate and the request are written with
   // nonblocking assignments, so this process sees each change only at a later edge.
   always @(posedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // One req transfer. Idle cycles come first so that valid, once raised,
   // stays high with a steady payload until the core takes it. Each path
   // through here makes at most one assignment to req_valid per edge.
   task automatic send_item(input logic [DIM_W-1:0] dim, input logic is_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{dim_value: dim, last: is_last};
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // Drop valid and wait until the checker holds no pending result. The
   // outstanding count is registered, so a stale nonzero only repeats the wait.
   task automatic drain_results();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (costs_outstanding != 0);
   endtask

   function automatic logic [DIM_W-1:0] pick_dim(dim_profile_type profile);
      case (profile)
         DIMS_EXTREME:   return $urandom_range(1) ? 10'd1023 : 10'd1;
         DIMS_TINY:      return DIM_W'($urandom_range(4, 1));
         DIMS_NEAR_MAX:  return DIM_W'($urandom_range(1023, 1000));
         DIMS_WITH_ZERO: return DIM_W'($urandom_range(1023, 0));
         default:        return DIM_W'($urandom_range(1023, 1));
      endcase
   endfunction

   // One random chain. Most are short, since the table fill grows with the
   // cube of the length; a few fill the store exactly, a few overrun it, and
   // a few close after a single value.
   task automatic send_random_chain(output int unsigned len);
      int unsigned     roll;
      dim_profile_type profile;
      roll = $urandom_range(99);
      if (roll < 3)
         len = 1;
      else if (roll < 6)
         len = MAX_DIMS;
      else if (roll < 10)
         len = MAX_DIMS + $urandom_range(5, 1);
      else if (roll < 25)
         len = $urandom_range(24, 9);
      else
         len = $urandom_range(8, 2);
      roll = $urandom_range(9);
      if (roll < 5)
         profile = DIMS_UNIFORM;
      else if (roll == 5)
         profile = DIMS_EXTREME;
      else if (roll == 6)
         profile = DIMS_TINY;
      else if (roll == 7)
         profile = DIMS_NEAR_MAX;
      else
         profile = DIMS_WITH_ZERO;
      for (int unsigned n = 0; n < len; n++)
         send_item(pick_dim(profile), n == len - 1);
   endtask

   initial begin
      int unsigned phase_items;
      int unsigned chain_len;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed chains, no idling. A lone value must close with an error.
      send_item(10'd7, 1'b1);
      // A single matrix costs nothing, at both ends of the value range.
      send_item(10'd1023, 1'b0);
      send_item(10'd1023, 1'b1);
      send_item(10'd1, 1'b0);
      send_item(10'd1, 1'b1);
      // A zero dimension wipes out every product that touches it.
      send_item(10'd0, 1'b0);
      send_item(10'd1023, 1'b0);
      send_item(10'd5, 1'b1);
      // Largest product of a two-matrix chain.
      send_item(10'd1023, 1'b0);
      send_item(10'd1023, 1'b0);
      send_item(10'd1023, 1'b1);
      // Textbook chain where the left split wins by a wide margin.
      send_item(10'd10, 1'b0);
      send_item(10'd30, 1'b0);
      send_item(10'd5, 1'b0);
      send_item(10'd60, 1'b1);
      // Alternating extremes, where the order of splits matters a lot.
      send_item(10'd1023, 1'b0);
      send_item(10'd1, 1'b0);
      send_item(10'd1023, 1'b0);
      send_item(10'd1, 1'b0);
      send_item(10'd1023, 1'b1);

      // Random chains under each idle profile in turn.
      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = SEND_IDLE_PCT[p];
         recv_stall_pct <= RECV_STALL_PCT[p];
         phase_items = 0;
         while (phase_items < ITEMS_PER_PHASE) begin
            send_random_chain(chain_len);
            phase_items += chain_len;
         end
      end

      // Back pressure: first let everything drain with the sender quiet, then
      // hold rsp off for a long stretch while short chains keep coming. The
      // core parks one result on rsp, finishes another behind it and then has
      // to stall req until the hold-off ends.
      send_idle_pct  = 0;
      recv_stall_pct <= 0;
      drain_results();
      hold_requests <= hold_requests + 1;
      for (int c = 0; c < 6; c++)
         for (int n = 0; n < 3; n++)
            send_item(pick_dim(DIMS_UNIFORM), n == 2);

      // Wind down: nothing left to predict, then a short settle so a stray
      // transfer would still be caught by the checker.
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && costs_outstanding == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Watchdog for a hung handshake or a result that never arrives.
   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("Regression FAIL");
      $finish;
   end

endmodule
